// ===== rtl/moc_pkg.sv =====
package moc_pkg;

  localparam int DEF_TILE_WIDTH  = 256;
  localparam int DEF_TILE_HEIGHT = 256;

  localparam int ACC_W  = 48;
  localparam int WORK_W = 58;
  localparam int WSUM_W = 24;
  localparam int VAL_W  = 16;
  localparam int WGT_W  = 16;
  localparam int MODE_W = 3;

  // one quotient bit per step, dividend is |acc| * 256 plus half the divisor
  localparam int DIV_STEPS = 56;

  localparam logic [WGT_W-1:0]  ONE_Q8   = WGT_W'(256);
  localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};

  typedef enum logic [1:0] {
    OP_MERGE = 2'd0,
    OP_NORM  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST   = 3'd0,
    MODE_LAST    = 3'd1,
    MODE_MIN     = 3'd2,
    MODE_MAX     = 3'd3,
    MODE_MEAN    = 3'd4,
    MODE_FEATHER = 3'd5,
    MODE_BLEND   = 3'd6
  } mode_e;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_LAST;

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WORK_W-1:0] a);
    logic [WORK_W-ACC_W:0] hi;
    hi = a[WORK_W-1:ACC_W-1];
    if (hi == '0 || hi == '1) begin
      return a[ACC_W-1:0];
    end else if (a[WORK_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  // floor shift by eight, then clamp to the sixteen bit range
  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-9:0] s;
    logic [ACC_W-8-VAL_W:0] hi;
    s  = a[ACC_W-1:8];
    hi = s[ACC_W-9:VAL_W-1];
    if (hi == '0 || hi == '1) begin
      return s[VAL_W-1:0];
    end else if (s[ACC_W-9]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/moc_if.sv =====
interface moc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [7:0]        cell_x;
  logic [7:0]        cell_y;
  logic signed [15:0] sample_value;
  logic [15:0]       sample_weight;

  modport source (
    output valid, opcode, cell_x, cell_y, sample_value, sample_weight,
    input  ready
  );
  modport sink (
    input  valid, opcode, cell_x, cell_y, sample_value, sample_weight,
    output ready
  );
endinterface

interface moc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_value;
  logic               cell_valid;
  logic [23:0]        weight_total;

  modport source (
    output valid, cell_value, cell_valid, weight_total,
    input  ready
  );
  modport sink (
    input  valid, cell_value, cell_valid, weight_total,
    output ready
  );
endinterface

// ===== rtl/moc_ram.sv =====
module moc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mosaic_overlap_combine_top.sv =====
// channel   dir  handshake       payload
// in_i      in   valid / ready   opcode, cell_x, cell_y, sample_value, sample_weight
// out_o     out  valid / ready   cell_value, cell_valid, weight_total
// cfg       in   cfg_we_i        cfg_wdata_i = overlap_mode
//
// one request at a time, with in_i.ready low until it is done: outside the tile it goes straight to
// the result, otherwise it runs through the cell memory read-modify-write, the shared multiplier
// and adder, and the 56 step divider; normalize skips the divider on a no-data cell
// after reset a clearing pass writes every no-data flag, one cell a cycle, with in_i.ready low.
// a finished result waits in the output register while the next request is taken
module mosaic_overlap_combine_top import moc_pkg::*; #(
  parameter int TILE_WIDTH  = DEF_TILE_WIDTH,
  parameter int TILE_HEIGHT = DEF_TILE_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  moc_in_if.sink            in_i,
  moc_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i
);

  localparam int EFF_W  = (TILE_WIDTH < 256) ? TILE_WIDTH : 256;
  localparam int EFF_H  = (TILE_HEIGHT < 256) ? TILE_HEIGHT : 256;
  localparam int DEPTH  = EFF_W * EFF_H;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int DATA_W = ACC_W + WSUM_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_MUL, S_MUL2, S_CMP, S_ADD,
    S_ABS, S_RND, S_DIV, S_FIX, S_WRITE, S_RES
  } state_e;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic                out_valid_q, out_valid_d;

  opcode_e             op_q, op_d;
  logic signed [VAL_W-1:0] sv_q, sv_d;
  logic [WGT_W-1:0]    sw_q, sw_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic                has_q, has_d;
  logic signed [WORK_W-1:0] acc_q, acc_d;
  logic signed [WORK_W-1:0] tmp_q, tmp_d;
  logic [WSUM_W-1:0]   w_q, w_d;
  logic [WSUM_W-1:0]   rem_q, rem_d;
  logic                neg_q, neg_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  logic                out_cvalid_q, out_cvalid_d;
  logic [WSUM_W-1:0]   out_wtotal_q, out_wtotal_d;

  logic                in_fire, in_tile, load_out;
  logic [ADDR_W-1:0]   rd_addr;
  logic [DATA_W-1:0]   data_rd;
  logic                has_rd;
  logic signed [ACC_W-1:0] acc_rd;
  logic [WSUM_W-1:0]   w_rd;
  logic signed [WORK_W-1:0] v_ext;
  logic [8:0]          blend_c, blend_cc;
  logic [WGT_W-1:0]    w_inc;
  logic [WSUM_W:0]     w_sum;
  logic [WSUM_W-1:0]   w_sat;

  // shared multiplier and adder
  logic signed [ACC_W-1:0]   mul_x;
  logic signed [16:0]        mul_y;
  logic signed [ACC_W+16:0]  prod_full;
  logic signed [WORK_W-1:0]  prod;
  logic [WORK_W-1:0]         add_a, add_b, sum;
  logic                      add_ci;
  logic                      cmp_take, div_bit;

  logic                data_we, flag_we, flag_wdata;
  logic [ADDR_W-1:0]   flag_waddr;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_tile    = (int'(in_i.cell_x) < TILE_WIDTH) && (int'(in_i.cell_y) < TILE_HEIGHT);
  assign rd_addr    = ADDR_W'(int'(in_i.cell_y) * EFF_W + int'(in_i.cell_x));

  assign acc_rd = data_rd[DATA_W-1:WSUM_W];
  assign w_rd   = data_rd[WSUM_W-1:0];

  assign v_ext    = WORK_W'($signed({sv_q, 8'd0}));
  assign blend_c  = (sw_q > WGT_W'(256)) ? 9'd256 : sw_q[8:0];
  assign blend_cc = 9'd256 - blend_c;

  assign w_inc = (mode_q == MODE_MEAN) ? ONE_Q8 : sw_q;
  assign w_sum = {1'b0, w_q} + {{(WSUM_W+1-WGT_W){1'b0}}, w_inc};
  assign w_sat = w_sum[WSUM_W] ? WSUM_MAX : w_sum[WSUM_W-1:0];

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    if (state_q == S_MUL && mode_q == MODE_BLEND) begin
      mul_x = acc_q[ACC_W-1:0];
      mul_y = $signed({8'd0, blend_cc});
    end else if (state_q == S_MUL) begin
      mul_x = ACC_W'(sv_q);
      mul_y = $signed({1'b0, sw_q});
    end else if (state_q == S_MUL2) begin
      mul_x = ACC_W'(sv_q);
      mul_y = $signed({8'd0, blend_c});
    end
  end

  assign prod_full = mul_x * mul_y;
  assign prod      = prod_full[WORK_W-1:0];

  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    unique case (state_q)
      S_CMP: begin
        add_a  = acc_q;
        add_b  = ~v_ext;
        add_ci = 1'b1;
      end
      S_ADD: begin
        if (mode_q == MODE_BLEND) begin
          add_a = tmp_q;
          add_b = {acc_q[WORK_W-9:0], 8'd0};
        end else begin
          add_a = has_q ? acc_q : '0;
          add_b = tmp_q;
        end
      end
      S_ABS: begin
        add_a  = acc_q[WORK_W-1] ? ~acc_q : acc_q;
        add_ci = acc_q[WORK_W-1];
      end
      S_RND: begin
        if (op_q == OP_NORM) begin
          add_a = {acc_q[WORK_W-9:0], 8'd0};
          add_b = {{(WORK_W-WSUM_W+1){1'b0}}, w_q[WSUM_W-1:1]};
        end else begin
          add_a = acc_q;
          add_b = WORK_W'(128);
        end
      end
      S_DIV: begin
        add_a  = {{(WORK_W-WSUM_W-1){1'b0}}, rem_q, acc_q[DIV_STEPS-1]};
        add_b  = ~{{(WORK_W-WSUM_W){1'b0}}, w_q};
        add_ci = 1'b1;
      end
      S_FIX: begin
        add_a  = neg_q ? ~acc_q : acc_q;
        add_ci = neg_q;
      end
      default: begin
      end
    endcase
  end

  assign sum = add_a + add_b + WORK_W'(add_ci);

  // difference acc - v: minimum takes v when it is above zero, maximum when below
  assign cmp_take = (mode_q == MODE_MIN) ? (!sum[WORK_W-1] && (sum != '0)) : sum[WORK_W-1];
  assign div_bit  = !sum[WORK_W-1];

  assign load_out = (state_q == S_RES) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    clr_cnt_d    = clr_cnt_q;
    div_cnt_d    = div_cnt_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    sv_d         = sv_q;
    sw_d         = sw_q;
    addr_d       = addr_q;
    has_d        = has_q;
    acc_d        = acc_q;
    tmp_d        = tmp_q;
    w_d          = w_q;
    rem_d        = rem_q;
    neg_d        = neg_q;
    out_value_d  = out_value_q;
    out_cvalid_d = out_cvalid_q;
    out_wtotal_d = out_wtotal_q;

    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_d   = opcode_e'(in_i.opcode);
          sv_d   = in_i.sample_value;
          sw_d   = in_i.sample_weight;
          addr_d = rd_addr;
          if (in_tile) begin
            state_d = S_READ;
          end else begin
            has_d   = 1'b0;
            state_d = S_RES;
          end
        end
      end
      S_READ: begin
        has_d = has_rd;
        acc_d = WORK_W'(acc_rd);
        w_d   = w_rd;
        tmp_d = v_ext;
        unique case (op_q)
          OP_CLEAR: begin
            has_d   = 1'b0;
            acc_d   = '0;
            w_d     = '0;
            state_d = S_WRITE;
          end
          OP_READ: state_d = S_RES;
          OP_NORM: state_d = (has_rd && w_rd != '0) ? S_ABS : S_RES;
          OP_MERGE: begin
            if (mode_q == MODE_FIRST || mode_q == MODE_LAST || mode_q == MODE_MIN ||
                mode_q == MODE_MAX || mode_q == MODE_BLEND) begin
              if (!has_rd) begin
                acc_d = v_ext;
                w_d   = '0;
              end
            end
            unique case (mode_q)
              MODE_FIRST: begin
                has_d   = 1'b1;
                state_d = S_WRITE;
              end
              MODE_LAST: begin
                acc_d   = v_ext;
                has_d   = 1'b1;
                state_d = S_WRITE;
              end
              MODE_MIN, MODE_MAX: begin
                has_d   = 1'b1;
                state_d = has_rd ? S_CMP : S_WRITE;
              end
              MODE_MEAN:    state_d = S_ADD;
              MODE_FEATHER: state_d = S_MUL;
              MODE_BLEND: begin
                has_d   = 1'b1;
                state_d = has_rd ? S_MUL : S_WRITE;
              end
              default: state_d = S_RES;
            endcase
          end
          default: state_d = S_RES;
        endcase
      end
      S_CMP: begin
        if (cmp_take) begin
          acc_d = v_ext;
        end
        state_d = S_WRITE;
      end
      S_MUL: begin
        tmp_d   = prod;
        state_d = (mode_q == MODE_BLEND) ? S_MUL2 : S_ADD;
      end
      S_MUL2: begin
        acc_d   = prod;
        state_d = S_ADD;
      end
      S_ADD: begin
        if (mode_q == MODE_BLEND) begin
          acc_d   = $signed(sum);
          state_d = S_ABS;
        end else begin
          acc_d   = WORK_W'(sat48($signed(sum)));
          w_d     = has_q ? w_sat : WSUM_W'(w_inc);
          has_d   = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_ABS: begin
        neg_d   = acc_q[WORK_W-1];
        acc_d   = $signed(sum);
        state_d = S_RND;
      end
      S_RND: begin
        if (op_q == OP_NORM) begin
          acc_d     = $signed(sum);
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end else begin
          acc_d   = $signed({8'd0, sum[WORK_W-1:8]});
          state_d = S_FIX;
        end
      end
      S_DIV: begin
        rem_d     = div_bit ? sum[WSUM_W-1:0] : {rem_q[WSUM_W-2:0], acc_q[DIV_STEPS-1]};
        // dividend bits shift out at the top, quotient bits fill in from below
        acc_d     = {{(WORK_W-DIV_STEPS){1'b0}}, acc_q[DIV_STEPS-2:0], div_bit};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        acc_d = WORK_W'(sat48($signed(sum)));
        if (op_q == OP_NORM) begin
          w_d = WSUM_W'(ONE_Q8);
        end
        state_d = S_WRITE;
      end
      S_WRITE: state_d = S_RES;
      S_RES: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          out_cvalid_d = has_q;
          out_value_d  = has_q ? sat16(acc_q[ACC_W-1:0]) : '0;
          out_wtotal_d = has_q ? w_q : '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= MODE_RESET;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      clr_cnt_q   <= clr_cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    sv_q         <= sv_d;
    sw_q         <= sw_d;
    addr_q       <= addr_d;
    has_q        <= has_d;
    acc_q        <= acc_d;
    tmp_q        <= tmp_d;
    w_q          <= w_d;
    rem_q        <= rem_d;
    neg_q        <= neg_d;
    out_value_q  <= out_value_d;
    out_cvalid_q <= out_cvalid_d;
    out_wtotal_q <= out_wtotal_d;
  end

  assign data_we    = (state_q == S_WRITE);
  assign flag_we    = (state_q == S_WRITE) || (state_q == S_CLEAR);
  assign flag_waddr = (state_q == S_CLEAR) ? clr_cnt_q : addr_q;
  assign flag_wdata = (state_q == S_CLEAR) ? 1'b0 : has_q;

  // no-data flags, swept to zero after reset
  moc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (rd_addr),
    .rdata_o (has_rd)
  );

  // accumulator and weight sum, read on every request but used only for cells that hold data
  moc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (addr_q),
    .wdata_i ({acc_q[ACC_W-1:0], w_q}),
    .raddr_i (rd_addr),
    .rdata_o (data_rd)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.cell_value   = out_value_q;
  assign out_o.cell_valid   = out_cvalid_q;
  assign out_o.weight_total = out_wtotal_q;

endmodule

// ===== rtl/moc_checker.sv =====
module moc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] cell_value_i,
  input logic        cell_valid_i,
  input logic [23:0] weight_total_i
);

  // ready is low right after every accepted request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high right after a request");

  // a no-data cell reports zero value and zero weight
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !cell_valid_i |-> cell_value_i == 16'd0 && weight_total_i == 24'd0)
    else $error("no-data result with nonzero fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_value_i) &&
      $stable(cell_valid_i) && $stable(weight_total_i))
    else $error("stalled result changed");

endmodule

bind mosaic_overlap_combine_top moc_checker u_moc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .cell_value_i   (out_o.cell_value),
  .cell_valid_i   (out_o.cell_valid),
  .weight_total_i (out_o.weight_total)
);
